### hw/rtl/assert_macros.svh
// Concurrent assertion helpers used by the dsc_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/dsc_pkg.sv
`timescale 1ns / 1ps
package dsc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CFG_DW   = 64;
    localparam int ADDR_W   = 6;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int WIDE_W   = 68;
    localparam int TANH_ENTRIES = 257;
    localparam int TIDX_W   = 8;
    localparam int TAB_W    = 24;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [TAB_W-1:0] tanh_tab_t [TANH_ENTRIES];

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_DRIVE_GAIN  = 3'd0;
    localparam logic [2:0] REG_OUTPUT_COMP = 3'd1;
    localparam logic [2:0] REG_BIAS_NOM    = 3'd2;
    localparam logic [2:0] REG_BIAS_COEFF  = 3'd3;
    localparam logic [2:0] REG_SHAPER_MODE = 3'd4;
    localparam logic [2:0] REG_STAGE_EN    = 3'd5;
    localparam logic [2:0] REG_PRE_SHELF   = 3'd6;
    localparam logic [2:0] REG_DE_SHELF    = 3'd7;

    localparam logic [1:0] MODE_BYPASS = 2'd0;
    localparam logic [1:0] MODE_EVEN   = 2'd1;
    localparam logic [1:0] MODE_CUBIC  = 2'd2;

    localparam int EN_TANH  = 0;
    localparam int EN_CLIP  = 1;
    localparam int EN_SHELF = 2;

    localparam logic [23:0] RST_DRIVE_GAIN  = 24'd65536;
    localparam logic [17:0] RST_OUTPUT_COMP = 18'd65536;
    localparam logic [15:0] RST_BIAS_COEFF  = 16'd65000;
    localparam logic [16:0] UNITY_Q16       = 17'd65536;

    localparam logic signed [MUL_W-1:0] K_035     = 33'sd5872026;
    localparam logic signed [MUL_W-1:0] K_THIRD   = 33'sd5592405;
    localparam logic signed [MUL_W-1:0] K_1P6     = 33'sd26843546;
    localparam logic signed [MUL_W-1:0] K_INV_T16 = 33'sd18203090;
    localparam logic signed [MUL_W-1:0] K_DC      = 33'sd16768827;

    typedef struct packed {
        logic        [23:0] drive_gain;
        logic        [17:0] output_comp;
        logic signed [23:0] bias_nominal;
        logic        [15:0] bias_coeff;
        logic        [1:0]  shaper_mode;
        logic        [2:0]  stage_en;
        logic        [59:0] pre_co;
        logic        [59:0] de_co;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    function automatic wide_t rnd(input wide_t v, input int unsigned s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input wide_t v);
        if (v > wide_t'(24'sh7F_FFFF)) return 24'sh7F_FFFF;
        if (v < wide_t'(24'sh80_0000)) return 24'sh80_0000;
        return 24'(v);
    endfunction

    function automatic logic signed [25:0] clamp_one(input wide_t v);
        if (v > wide_t'(26'sd16777216)) return 26'sd16777216;
        if (v < wide_t'(-26'sd16777216)) return -26'sd16777216;
        return 26'(v);
    endfunction

    function automatic logic signed [19:0] coef(input logic [59:0] co, input int unsigned k);
        return $signed(co[20*k +: 20]);
    endfunction

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(i/32): series at i/16384, then nine doublings in Q0.30
    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t tab;
        longint u;
        longint u2;
        longint u3;
        longint u5;
        longint t;
        longint den;
        longint half;
        half = longint'(1) <<< 29;
        for (int i = 0; i < TANH_ENTRIES; i++)
        begin
            u  = longint'(i) <<< 16;
            u2 = (u * u + half) >>> 30;
            u3 = (u2 * u + half) >>> 30;
            u5 = (u3 * u2 + half) >>> 30;
            t  = u - (u3 + 1) / 3 + (2 * u5 + 7) / 15;
            for (int k = 0; k < 9; k++)
            begin
                den = (longint'(1) <<< 30) + ((t * t + half) >>> 30);
                t = longint'(udiv(64'((t <<< 31) + (den >>> 1)), 64'(den)));
            end
            tab[i] = TAB_W'((t + 32) >>> 6);
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

### hw/rtl/dsc_if.sv
`timescale 1ns / 1ps
interface dsc_in_if import dsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface dsc_out_if import dsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

### hw/rtl/dsc_regs.sv
`timescale 1ns / 1ps
module dsc_regs import dsc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_gain   <= RST_DRIVE_GAIN;
            cfg_reg.output_comp  <= RST_OUTPUT_COMP;
            cfg_reg.bias_nominal <= '0;
            cfg_reg.bias_coeff   <= RST_BIAS_COEFF;
            cfg_reg.shaper_mode  <= MODE_BYPASS;
            cfg_reg.stage_en     <= '0;
            cfg_reg.pre_co       <= '0;
            cfg_reg.de_co        <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DRIVE_GAIN:  cfg_reg.drive_gain   <= pwdata[23:0];
                REG_OUTPUT_COMP: cfg_reg.output_comp  <= pwdata[17:0];
                REG_BIAS_NOM:    cfg_reg.bias_nominal <= $signed(pwdata[23:0]);
                REG_BIAS_COEFF:  cfg_reg.bias_coeff   <= pwdata[15:0];
                REG_SHAPER_MODE: cfg_reg.shaper_mode  <= pwdata[1:0];
                REG_STAGE_EN:    cfg_reg.stage_en     <= pwdata[2:0];
                REG_PRE_SHELF:   cfg_reg.pre_co       <= pwdata[59:0];
                REG_DE_SHELF:    cfg_reg.de_co        <= pwdata[59:0];
                default:         cfg_reg.stage_en     <= cfg_reg.stage_en;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DRIVE_GAIN:  prdata = CFG_DW'(cfg_reg.drive_gain);
            REG_OUTPUT_COMP: prdata = CFG_DW'(cfg_reg.output_comp);
            REG_BIAS_NOM:    prdata = CFG_DW'($unsigned(cfg_reg.bias_nominal));
            REG_BIAS_COEFF:  prdata = CFG_DW'(cfg_reg.bias_coeff);
            REG_SHAPER_MODE: prdata = CFG_DW'(cfg_reg.shaper_mode);
            REG_STAGE_EN:    prdata = CFG_DW'(cfg_reg.stage_en);
            REG_PRE_SHELF:   prdata = CFG_DW'(cfg_reg.pre_co);
            REG_DE_SHELF:    prdata = CFG_DW'(cfg_reg.de_co);
            default:         prdata = '0;
        endcase
    end

endmodule

### hw/rtl/dsc_mul.sv
`timescale 1ns / 1ps
module dsc_mul import dsc_pkg::*; (
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

### hw/rtl/dsc_tanh.sv
`timescale 1ns / 1ps
module dsc_tanh import dsc_pkg::*; (
    input  logic [TIDX_W-1:0]  idx,
    input  logic               sat,
    output logic [TAB_W-1:0]   base,
    output logic signed [TAB_W:0] diff
);

    logic [TIDX_W:0] lo_idx;
    logic [TIDX_W:0] hi_idx;
    logic [TAB_W-1:0] lo_val;
    logic [TAB_W-1:0] hi_val;

    assign lo_idx = {1'b0, idx};
    assign hi_idx = lo_idx + 9'd1;
    assign lo_val = TANH_TAB[lo_idx];
    assign hi_val = TANH_TAB[hi_idx];

    // past the end of the table the curve is flat
    assign base = sat ? TANH_TAB[TANH_ENTRIES-1] : lo_val;
    assign diff = $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});

endmodule

### hw/rtl/dsc_seq.sv
`timescale 1ns / 1ps
module dsc_seq import dsc_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       take,
    output seq_stat_t                  stat,
    output logic signed [SAMPLE_W-1:0] result,
    output logic signed [MUL_W-1:0]    mul_a,
    output logic signed [MUL_W-1:0]    mul_b,
    input  logic signed [PROD_W-1:0]   prod,
    output logic [TIDX_W-1:0]          tanh_idx,
    output logic                       tanh_sat,
    input  logic [TAB_W-1:0]           tanh_base,
    input  logic signed [TAB_W:0]      tanh_diff
);

    localparam int STEP_N = 46;

    typedef enum logic [STEP_N-1:0] {
        ST_IDLE     = STEP_N'(1) << 0,
        ST_DRV_M    = STEP_N'(1) << 1,
        ST_DRV_P    = STEP_N'(1) << 2,
        ST_PRE_B0   = STEP_N'(1) << 3,
        ST_PRE_B1   = STEP_N'(1) << 4,
        ST_PRE_A1   = STEP_N'(1) << 5,
        ST_PRE_Y    = STEP_N'(1) << 6,
        ST_BIAS_C   = STEP_N'(1) << 7,
        ST_BIAS_T   = STEP_N'(1) << 8,
        ST_ADD_BIAS = STEP_N'(1) << 9,
        ST_EV_ARG   = STEP_N'(1) << 10,
        ST_EV_TA    = STEP_N'(1) << 11,
        ST_EV_TB    = STEP_N'(1) << 12,
        ST_EV_TC    = STEP_N'(1) << 13,
        ST_EV_TD    = STEP_N'(1) << 14,
        ST_EV_SQM   = STEP_N'(1) << 15,
        ST_EV_SQP   = STEP_N'(1) << 16,
        ST_EV_KM    = STEP_N'(1) << 17,
        ST_EV_Y     = STEP_N'(1) << 18,
        ST_CU_CL    = STEP_N'(1) << 19,
        ST_CU_M2    = STEP_N'(1) << 20,
        ST_CU_P2    = STEP_N'(1) << 21,
        ST_CU_M3    = STEP_N'(1) << 22,
        ST_CU_P3    = STEP_N'(1) << 23,
        ST_CU_MK    = STEP_N'(1) << 24,
        ST_CU_R     = STEP_N'(1) << 25,
        ST_CU_Y     = STEP_N'(1) << 26,
        ST_SAT_M    = STEP_N'(1) << 27,
        ST_SAT_ARG  = STEP_N'(1) << 28,
        ST_SAT_TA   = STEP_N'(1) << 29,
        ST_SAT_TB   = STEP_N'(1) << 30,
        ST_SAT_TC   = STEP_N'(1) << 31,
        ST_SAT_TD   = STEP_N'(1) << 32,
        ST_SAT_KM   = STEP_N'(1) << 33,
        ST_SAT_Y    = STEP_N'(1) << 34,
        ST_CLIP     = STEP_N'(1) << 35,
        ST_DE_B0    = STEP_N'(1) << 36,
        ST_DE_B1    = STEP_N'(1) << 37,
        ST_DE_A1    = STEP_N'(1) << 38,
        ST_DE_Y     = STEP_N'(1) << 39,
        ST_OUT_M    = STEP_N'(1) << 40,
        ST_OUT_Y    = STEP_N'(1) << 41,
        ST_DC_M     = STEP_N'(1) << 42,
        ST_DC_Y     = STEP_N'(1) << 43,
        ST_BIAS_Y   = STEP_N'(1) << 44,
        ST_DONE     = STEP_N'(1) << 45
    } step_t;

    step_t state_reg;
    step_t state_next;

    // filter and bias memories
    logic signed [31:0] pre_in_reg;
    logic signed [31:0] pre_out_reg;
    logic signed [31:0] de_in_reg;
    logic signed [31:0] de_out_reg;
    logic signed [31:0] dc_in_reg;
    logic signed [31:0] dc_out_reg;
    logic signed [31:0] bias_reg;

    // working registers
    logic signed [24:0] x_reg;
    logic signed [31:0] y_reg;
    wide_t              acc_reg;
    logic signed [31:0] tgt_reg;
    logic signed [33:0] aux_reg;
    logic signed [25:0] xn_reg;
    logic signed [25:0] cl_reg;
    logic               tneg_reg;
    logic               tsat_reg;
    logic [TIDX_W-1:0]  tidx_reg;
    logic [18:0]        tfr_reg;
    logic [TAB_W-1:0]   tbase_reg;
    logic signed [TAB_W:0] td_reg;

    wide_t              p_w;
    logic signed [31:0] shelf_res;
    logic signed [31:0] bias_res;
    logic signed [31:0] dc_res;
    logic [33:0]        tmag;
    wide_t              t_val;
    logic [16:0]        g_lim;
    logic               curve;
    logic               active;

    assign p_w       = wide_t'(prod);
    assign shelf_res = sat32(rnd(acc_reg - p_w, 16));
    assign bias_res  = sat32(rnd(acc_reg + p_w, 16));
    assign dc_res    = sat32(wide_t'(y_reg) - wide_t'(dc_in_reg) + rnd(p_w, 24));
    assign tmag      = aux_reg[33] ? 34'(-aux_reg) : 34'(aux_reg);
    assign t_val     = wide_t'($signed({1'b0, tbase_reg})) + (p_w >>> 19);
    assign g_lim     = (cfg.drive_gain < 24'(UNITY_Q16)) ? cfg.drive_gain[16:0] : UNITY_Q16;
    assign curve     = cfg.stage_en[EN_SHELF];
    assign active    = (cfg.shaper_mode != MODE_BYPASS) || cfg.stage_en[EN_TANH]
                       || cfg.stage_en[EN_CLIP];

    assign tanh_idx  = tidx_reg;
    assign tanh_sat  = tsat_reg;

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign result    = sat24(rnd(wide_t'(y_reg), 1));

    always_comb
    begin
        if (state_reg == ST_IDLE)
            state_next = start ? ST_DRV_M : ST_IDLE;
        else if (state_reg == ST_DONE)
            state_next = take ? ST_IDLE : ST_DONE;
        else if (state_reg == ST_DC_Y)
            state_next = ST_DONE;
        else
            state_next = step_t'(state_reg << 1);
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DRV_M:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.drive_gain}));
            end
            ST_DRV_P:
            begin
                mul_a = MUL_W'(cfg.bias_nominal) <<< 1;
                mul_b = MUL_W'($signed({1'b0, g_lim}));
            end
            ST_PRE_B0:
            begin
                mul_a = MUL_W'(coef(cfg.pre_co, 0));
                mul_b = MUL_W'(y_reg);
            end
            ST_PRE_B1:
            begin
                mul_a = MUL_W'(coef(cfg.pre_co, 1));
                mul_b = MUL_W'(pre_in_reg);
            end
            ST_PRE_A1:
            begin
                mul_a = MUL_W'(coef(cfg.pre_co, 2));
                mul_b = MUL_W'(pre_out_reg);
            end
            ST_PRE_Y:
            begin
                mul_a = MUL_W'($signed({1'b0, cfg.bias_coeff}));
                mul_b = MUL_W'(bias_reg);
            end
            ST_BIAS_C:
            begin
                mul_a = MUL_W'($signed({1'b0, UNITY_Q16 - {1'b0, cfg.bias_coeff}}));
                mul_b = MUL_W'(tgt_reg);
            end
            ST_EV_TC, ST_SAT_TC:
            begin
                mul_a = MUL_W'(td_reg);
                mul_b = MUL_W'($signed({1'b0, tfr_reg}));
            end
            ST_EV_SQM:
            begin
                mul_a = MUL_W'(xn_reg);
                mul_b = MUL_W'(xn_reg);
            end
            ST_EV_KM:
            begin
                mul_a = K_035;
                mul_b = MUL_W'(aux_reg);
            end
            ST_CU_M2:
            begin
                mul_a = MUL_W'(cl_reg);
                mul_b = MUL_W'(cl_reg);
            end
            ST_CU_M3:
            begin
                mul_a = MUL_W'(aux_reg);
                mul_b = MUL_W'(cl_reg);
            end
            ST_CU_MK:
            begin
                mul_a = MUL_W'(aux_reg);
                mul_b = K_THIRD;
            end
            ST_SAT_M:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = K_1P6;
            end
            ST_SAT_KM:
            begin
                mul_a = MUL_W'(xn_reg);
                mul_b = K_INV_T16;
            end
            ST_DE_B0:
            begin
                mul_a = MUL_W'(coef(cfg.de_co, 0));
                mul_b = MUL_W'(y_reg);
            end
            ST_DE_B1:
            begin
                mul_a = MUL_W'(coef(cfg.de_co, 1));
                mul_b = MUL_W'(de_in_reg);
            end
            ST_DE_A1:
            begin
                mul_a = MUL_W'(coef(cfg.de_co, 2));
                mul_b = MUL_W'(de_out_reg);
            end
            ST_OUT_M:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'($signed({1'b0, cfg.output_comp}));
            end
            ST_DC_M:
            begin
                mul_a = K_DC;
                mul_b = MUL_W'(dc_out_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pre_in_reg  <= '0;
            pre_out_reg <= '0;
            de_in_reg   <= '0;
            de_out_reg  <= '0;
            dc_in_reg   <= '0;
            dc_out_reg  <= '0;
            bias_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_PRE_Y && curve)
            begin
                pre_in_reg  <= y_reg;
                pre_out_reg <= shelf_res;
            end
            if (state_reg == ST_BIAS_T)
                bias_reg <= bias_res;
            if (state_reg == ST_DE_Y && curve)
            begin
                de_in_reg  <= y_reg;
                de_out_reg <= shelf_res;
            end
            if (state_reg == ST_DC_Y && active)
            begin
                dc_in_reg  <= y_reg;
                dc_out_reg <= dc_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (start)
                    x_reg <= $signed({sample, 1'b0});
            ST_DRV_P:
                y_reg <= sat32(rnd(p_w, 16));
            ST_PRE_B0:
                tgt_reg <= sat32(rnd(p_w, 16));
            ST_PRE_B1, ST_DE_B1, ST_BIAS_C:
                acc_reg <= p_w;
            ST_PRE_A1, ST_DE_A1:
                acc_reg <= acc_reg + p_w;
            ST_PRE_Y, ST_DE_Y:
                if (curve)
                    y_reg <= shelf_res;
            ST_ADD_BIAS:
                if (active)
                    y_reg <= sat32(wide_t'(y_reg) + wide_t'(bias_reg));
            ST_EV_ARG:
                aux_reg <= 34'(rnd(wide_t'(y_reg), 2));
            ST_EV_TA, ST_SAT_TA:
            begin
                tneg_reg <= aux_reg[33];
                tsat_reg <= |tmag[33:27];
                tidx_reg <= tmag[26:19];
                // flat region: zero the slope so the base passes straight through
                tfr_reg  <= (|tmag[33:27]) ? '0 : tmag[18:0];
            end
            ST_EV_TB, ST_SAT_TB:
            begin
                tbase_reg <= tanh_base;
                td_reg    <= tanh_diff;
            end
            ST_EV_TD, ST_SAT_TD:
                xn_reg <= 26'(tneg_reg ? -t_val : t_val);
            ST_EV_SQP, ST_CU_P2, ST_CU_P3, ST_SAT_ARG:
                aux_reg <= 34'(rnd(p_w, 24));
            ST_EV_Y:
                if (cfg.shaper_mode == MODE_EVEN)
                    y_reg <= sat32(wide_t'(xn_reg) + rnd(p_w, 24));
            ST_CU_CL:
                cl_reg <= clamp_one(wide_t'(y_reg));
            ST_CU_R:
                aux_reg <= 34'(wide_t'(cl_reg) - rnd(p_w, 24));
            ST_CU_Y:
                if (cfg.shaper_mode == MODE_CUBIC)
                    y_reg <= sat32(rnd(wide_t'(aux_reg) + (wide_t'(aux_reg) <<< 1), 1));
            ST_SAT_Y:
                if (cfg.stage_en[EN_TANH])
                    y_reg <= sat32(rnd(p_w, 24));
            ST_CLIP:
                if (cfg.stage_en[EN_CLIP])
                    y_reg <= 32'(clamp_one(rnd(wide_t'(y_reg) + (wide_t'(y_reg) <<< 2), 1)));
            ST_OUT_Y:
                y_reg <= sat32(rnd(p_w, 16));
            ST_DC_Y:
                if (active)
                    y_reg <= dc_res;
            default:
                acc_reg <= acc_reg;
        endcase
    end

endmodule

### hw/rtl/drive_saturator_chain.sv
`timescale 1ns / 1ps
// A sample is accepted only while the sequencer is idle and runs every step before
// the next is taken; the result is offered from an output register. Every product
// of the chain goes through the one registered 33x33 multiplier, stepped by the sequencer.
// One finished result may wait in the output register while the next sample
// runs; a second one holds the sequencer, and so the input, until it drains.
// Reset (rst_n, async low) restores register defaults and clears all filter and bias state.
module drive_saturator_chain import dsc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    dsc_in_if.sink            sample_ch,
    dsc_out_if.source         result_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t                       cfg;
    seq_stat_t                  stat;
    logic                       start;
    logic                       take;
    logic signed [SAMPLE_W-1:0] seq_result;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [TIDX_W-1:0]          tanh_idx;
    logic                       tanh_sat;
    logic [TAB_W-1:0]           tanh_base;
    logic signed [TAB_W:0]      tanh_diff;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    assign sample_ch.ready     = stat.idle;
    assign start               = sample_ch.valid & stat.idle;
    // hand the result over once the output slot is empty or draining
    assign take                = stat.done & (~out_valid_reg | result_ch.ready);
    assign result_ch.valid     = out_valid_reg;
    assign result_ch.sample_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= seq_result;
    end

    dsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dsc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    dsc_tanh u_tanh (
        .idx  (tanh_idx),
        .sat  (tanh_sat),
        .base (tanh_base),
        .diff (tanh_diff)
    );

    dsc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (start),
        .sample    (sample_ch.sample_in),
        .take      (take),
        .stat      (stat),
        .result    (seq_result),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .prod      (prod),
        .tanh_idx  (tanh_idx),
        .tanh_sat  (tanh_sat),
        .tanh_base (tanh_base),
        .tanh_diff (tanh_diff)
    );

endmodule

### hw/rtl/dsc_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsc_chk import dsc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SAMPLE_W-1:0] sample_out,
    input logic                psel,
    input logic                penable,
    input logic                pready
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(sample_out))
    `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))
    `ASSERT_IMPLIES(a_apb_no_wait, clk, rst_n, psel && penable, pready)

endmodule

bind drive_saturator_chain dsc_chk u_dsc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .sample_out (result_ch.sample_out),
    .psel       (psel),
    .penable    (penable),
    .pready     (pready)
);
